// ----- rtl/msd_pkg.sv -----
// Shared types and constants for the multi-switch debouncer.
package msd_pkg;

  localparam int SWITCH_CAP_DEF = 16;

  localparam int KIND_W   = 2;
  localparam int ID_W     = 4;
  localparam int TIME_W   = 32;
  localparam int PERIOD_W = 15;
  localparam int COUNT_W  = 5;
  localparam int MASK_W   = 16;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam int IN_DATA_W  = 40;
  localparam int IN_USER_W  = 8;
  localparam int OUT_DATA_W = 16;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_MS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SWITCH_CNT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BUTTON      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_LOW  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LINKED      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_LINK_INIT   = 3'd5;

  localparam logic [PERIOD_W-1:0] DEBOUNCE_RESET = 15'd10;

  typedef enum logic [KIND_W-1:0] {
    KIND_POLL     = 2'd0,
    KIND_BTN_POLL = 2'd1,
    KIND_CLR_ONE  = 2'd2,
    KIND_CLR_ALL  = 2'd3
  } kind_t;

  typedef struct packed {
    logic [PERIOD_W-1:0] debounce_ms;
    logic [COUNT_W-1:0]  switch_count;
    logic [MASK_W-1:0]   button_mask;
    logic [MASK_W-1:0]   active_low_mask;
    logic [MASK_W-1:0]   linked_mask;
    logic [MASK_W-1:0]   link_init_mask;
  } cfg_t;

  // One switch's entry in the state memory.
  typedef struct packed {
    logic              flipped;
    logic              deb_on;
    logic [TIME_W-1:0] timer_start;
  } rec_t;

  // Outcome of one item, from the update logic to the top level.
  typedef struct packed {
    logic poll;
    logic report;
    logic pend_next;
    logic switched;
    logic toggle_on;
    logic pending;
    logic out_level;
  } upd_t;

endpackage

// ----- rtl/msd_rec_ram.sv -----
// State memory of the debouncer: one entry per switch, registered read, valid bits.
module msd_rec_ram #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_en,
  input  logic [AW-1:0]     wr_addr,
  input  msd_pkg::rec_t     wr_data,
  input  logic              rd_en,
  input  logic [AW-1:0]     rd_addr,
  output msd_pkg::rec_t     rd_data
);
  import msd_pkg::*;

  rec_t             mem [DEPTH];
  logic [DEPTH-1:0] ent_valid;
  rec_t             rd_q;
  logic             rd_hit;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  // An entry never written since reset reads as all zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      ent_valid <= '0;
      rd_hit    <= 1'b0;
    end else begin
      if (rd_en) begin
        rd_hit <= ent_valid[rd_addr];
      end
      if (wr_en) begin
        ent_valid[wr_addr] <= 1'b1;
      end
    end
  end

  assign rd_data = rd_hit ? rd_q : '0;

endmodule

// ----- rtl/msd_update.sv -----
// Debounce rules: next state of one switch and the result fields for one item.
module msd_update (
  input  msd_pkg::kind_t              kind,
  input  logic [msd_pkg::ID_W-1:0]    sel_id,
  input  logic                        pin_level,
  input  logic [msd_pkg::TIME_W-1:0]  now_ms,
  input  logic                        id_valid,
  input  msd_pkg::cfg_t               cfg,
  input  msd_pkg::rec_t               cur,
  input  logic                        pend_cur,
  output msd_pkg::rec_t               nxt,
  output msd_pkg::upd_t               upd
);
  import msd_pkg::*;

  logic              btn;
  logic              on;
  logic              linked;
  logic [TIME_W-1:0] age;
  logic              elapsed;
  logic              start;
  logic              pend_eff;
  logic              el;
  logic              poll;
  logic              report;
  logic              pend_n;

  assign btn      = cfg.button_mask[sel_id];
  assign linked   = cfg.linked_mask[sel_id];
  assign on       = pin_level ^ cfg.active_low_mask[sel_id];
  assign age      = now_ms - cur.timer_start;
  assign elapsed  = age >= {{(TIME_W-PERIOD_W){1'b0}}, cfg.debounce_ms};
  assign start    = (on != cur.deb_on) && !pend_cur;
  assign pend_eff = pend_cur || start;
  // A toggle that only now starts its transition has elapsed only for a zero period.
  assign el       = start ? (cfg.debounce_ms == '0) : elapsed;

  always_comb begin
    nxt    = cur;
    pend_n = pend_cur;
    report = 1'b0;
    poll   = 1'b0;
    unique case (kind)
      KIND_POLL:     poll = id_valid;
      KIND_BTN_POLL: poll = id_valid && btn;
      KIND_CLR_ONE,
      KIND_CLR_ALL:  pend_n = 1'b0;
      default:       poll = 1'b0;
    endcase
    if (poll) begin
      if (btn) begin
        if (on) begin
          pend_n          = 1'b1;
          nxt.timer_start = now_ms;
        end else if (pend_cur && elapsed) begin
          pend_n = 1'b0;
          report = 1'b1;
        end
      end else begin
        if (start) begin
          nxt.timer_start = now_ms;
        end
        if (pend_eff && el) begin
          nxt.deb_on = ~cur.deb_on;
          pend_n     = 1'b0;
          report     = 1'b1;
        end else if (start) begin
          pend_n = 1'b1;
        end
      end
    end
    if (report && (kind == KIND_POLL) && linked) begin
      nxt.flipped = ~cur.flipped;
    end
  end

  assign upd.poll      = poll;
  assign upd.report    = report;
  assign upd.pend_next = pend_n;
  assign upd.switched  = report && (kind == KIND_POLL);
  assign upd.toggle_on = id_valid && !btn && nxt.deb_on;
  assign upd.pending   = id_valid && pend_n;
  assign upd.out_level = id_valid && linked && (cfg.link_init_mask[sel_id] ^ nxt.flipped);

endmodule

// ----- rtl/multi_switch_debouncer.sv -----
// Top level of the multi-switch debouncer.
//
// Items arrive on the s_ stream: s_tuser carries the kind (poll, button poll,
// clear one pending, clear all pending) and s_tdata the switch id, the sampled
// pin level and a wrapping millisecond timestamp. Each item gives exactly one
// result item on the m_ stream with the switch's debounced status.
// Items pass the update stage and output register at one item per cycle while
// m_ keeps up: one item's memory read overlaps the update and write-back of
// the one before, and a same-switch write is forwarded to the following item.
// The per-switch timer start, debounced level and linked-output flip live in a
// synchronous memory with a registered read; pending flags are a flag vector
// so that a clear-all clears the flags of all configured switches at once.
// Reset empties both channels, sets the configuration to its default values
// and makes every switch read as off, not pending and never flipped.
// When the receiver stalls, the result waits in the output register, one more
// item may sit in the update stage, and s_tready then falls until m_tready.
// Configuration is written through cfg_we, cfg_index and cfg_data; the user
// must do so only while idle, which the block itself does not enforce.
module multi_switch_debouncer #(
  parameter int SWITCH_CAP = msd_pkg::SWITCH_CAP_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [msd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [msd_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // id [3:0], pin_level [4], now_ms [36:5], zero fill above.
  input  logic [msd_pkg::IN_DATA_W-1:0]     s_tdata,
  // kind [1:0], zero fill above.
  input  logic [msd_pkg::IN_USER_W-1:0]     s_tuser,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // id_valid [0], switched [1], toggle_on [2], pending [3], output_level [4],
  // last_id [8:5], zero fill above.
  output logic [msd_pkg::OUT_DATA_W-1:0]    m_tdata
);
  import msd_pkg::*;

  localparam int DEPTH = (SWITCH_CAP < (1 << ID_W)) ? SWITCH_CAP : (1 << ID_W);
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [COUNT_W-1:0] DEPTH_CNT = COUNT_W'(DEPTH);

  cfg_t cfg;

  logic              s1_valid;
  kind_t             s1_kind;
  logic [ID_W-1:0]   s1_id;
  logic              s1_pin;
  logic [TIME_W-1:0] s1_now;

  logic              accept;
  logic              advance;
  logic [AW-1:0]     rd_addr;
  logic [AW-1:0]     s1_idx;
  rec_t              ram_rd;
  rec_t              cur;
  rec_t              nxt;
  upd_t              upd;
  logic              wr_en;

  logic              fwd_valid;
  logic [AW-1:0]     fwd_addr;
  rec_t              fwd_rec;

  logic [DEPTH-1:0]  pend_q;
  logic [ID_W-1:0]   last_q;
  logic [ID_W-1:0]   last_next;
  logic [COUNT_W-1:0] eff_n;
  logic              id_valid;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_ms     <= DEBOUNCE_RESET;
      cfg.switch_count    <= '0;
      cfg.button_mask     <= '0;
      cfg.active_low_mask <= '0;
      cfg.linked_mask     <= '0;
      cfg.link_init_mask  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DEBOUNCE_MS: cfg.debounce_ms     <= cfg_data[PERIOD_W-1:0];
        REG_SWITCH_CNT:  cfg.switch_count    <= cfg_data[COUNT_W-1:0];
        REG_BUTTON:      cfg.button_mask     <= cfg_data[MASK_W-1:0];
        REG_ACTIVE_LOW:  cfg.active_low_mask <= cfg_data[MASK_W-1:0];
        REG_LINKED:      cfg.linked_mask     <= cfg_data[MASK_W-1:0];
        REG_LINK_INIT:   cfg.link_init_mask  <= cfg_data[MASK_W-1:0];
        default: ;
      endcase
    end
  end

  assign advance  = s1_valid && (!m_tvalid || m_tready);
  assign s_tready = !s1_valid || advance;
  assign accept   = s_tvalid && s_tready;
  assign rd_addr  = s_tdata[AW-1:0];
  assign s1_idx   = s1_id[AW-1:0];

  // Update stage holds the item whose memory read is in flight.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_kind <= kind_t'(s_tuser[KIND_W-1:0]);
      s1_id   <= s_tdata[ID_W-1:0];
      s1_pin  <= s_tdata[ID_W];
      s1_now  <= s_tdata[ID_W+TIME_W:ID_W+1];
    end
  end

  msd_rec_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (wr_en),
    .wr_addr (s1_idx),
    .wr_data (nxt),
    .rd_en   (accept),
    .rd_addr (rd_addr),
    .rd_data (ram_rd)
  );

  // The last write always matches memory, so it may stand in for a read that
  // raced with it.
  assign cur = (fwd_valid && (fwd_addr == s1_idx)) ? fwd_rec : ram_rd;

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_valid <= 1'b0;
    end else if (wr_en) begin
      fwd_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      fwd_addr <= s1_idx;
      fwd_rec  <= nxt;
    end
  end

  assign eff_n    = (cfg.switch_count > DEPTH_CNT) ? DEPTH_CNT : cfg.switch_count;
  assign id_valid = {1'b0, s1_id} < eff_n;

  msd_update u_update (
    .kind      (s1_kind),
    .sel_id    (s1_id),
    .pin_level (s1_pin),
    .now_ms    (s1_now),
    .id_valid  (id_valid),
    .cfg       (cfg),
    .cur       (cur),
    .pend_cur  (id_valid ? pend_q[s1_idx] : 1'b0),
    .nxt       (nxt),
    .upd       (upd)
  );

  assign wr_en     = advance && upd.poll;
  assign last_next = upd.report ? s1_id : last_q;

  // Pending flags and the last reported id.
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_q <= '0;
      last_q <= '0;
    end else if (advance) begin
      last_q <= last_next;
      if (s1_kind == KIND_CLR_ALL) begin
        for (int i = 0; i < DEPTH; i++) begin
          if (COUNT_W'(i) < eff_n) begin
            pend_q[i] <= 1'b0;
          end
        end
      end else if (id_valid) begin
        pend_q[s1_idx] <= upd.pend_next;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata <= {{(OUT_DATA_W-5-ID_W){1'b0}}, last_next, upd.out_level, upd.pending,
                  upd.toggle_on, upd.switched, id_valid};
    end
  end

endmodule
